// File: src/bfki_pkg.sv
// ============================================================================
// bfki_pkg
// Shared constants, types and the CORDIC arctangent table for the Bessel
// integral unit.
// ============================================================================
package bfki_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS         = 16;
    localparam int CORDIC_ITERATIONS = 18;
    localparam int MAX_STEPS_LOG2    = 14;
    localparam int MIN_STEPS_LOG2    = 4;
    localparam int STEPS_RESET       = 10;

    localparam int X_W      = 21;
    localparam int ORDER_W  = 4;
    localparam int STEPS_W  = 4;
    localparam int OUT_W    = FRAC_BITS + 2;

    // Phase is one turn per 2^32.
    localparam int PHASE_W  = 32;
    localparam int PSH_W    = $clog2(PHASE_W);

    // CORDIC datapath: vector components and residual angle.
    localparam int CORD_FRAC = 30;
    localparam int CORD_W    = 33;
    localparam int ANGLE_W   = 34;
    localparam int ATAN_TABLE_LEN = 28;
    localparam int ATAN_IDX_W     = $clog2(ATAN_TABLE_LEN);
    localparam int ITER_W         = $clog2(CORDIC_ITERATIONS);
    localparam logic [CORD_W-1:0] CORDIC_GAIN = CORD_W'(64'd652032874);

    // Phase of x*sin(theta): product floored to RAD_FRAC fraction bits of radians.
    localparam int RAD_FRAC  = 24;
    localparam int RAD_SHIFT = FRAC_BITS + CORD_FRAC - RAD_FRAC;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam logic [MUL_W-1:0] INV_TWO_PI = MUL_W'(64'd683565276);

    // Sample rounding and accumulation.
    localparam int CF_SHIFT = CORD_FRAC - FRAC_BITS;
    localparam int CF_W     = CORD_W - CF_SHIFT;
    localparam int SUM_W    = 34;

    // Panel counter and clamped step exponent.
    localparam int K_W = MAX_STEPS_LOG2 + 1;
    localparam int S_W = $clog2(MAX_STEPS_LOG2 + 2);

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_status_t;

    // Arctangent of 2^-i in turns times 2^32, rounded to nearest.
    function automatic logic [PHASE_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/bfki_cordic.sv
// ============================================================================
// bfki_cordic
// Rotation-mode CORDIC, one micro-rotation per clock, with quadrant folding.
// ============================================================================
module bfki_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [bfki_pkg::PHASE_W-1:0]          phase,
    output bfki_pkg::cordic_status_t              status,
    output logic signed [bfki_pkg::CORD_W-1:0]    cos_value,
    output logic signed [bfki_pkg::CORD_W-1:0]    sin_value
);

    localparam logic signed [bfki_pkg::ANGLE_W-1:0] QUARTER_TURN =
        bfki_pkg::ANGLE_W'(64'sh4000_0000);
    localparam logic signed [bfki_pkg::ANGLE_W-1:0] HALF_TURN =
        bfki_pkg::ANGLE_W'(64'sh8000_0000);

    logic signed [bfki_pkg::CORD_W-1:0]  x_reg, x_next;
    logic signed [bfki_pkg::CORD_W-1:0]  y_reg, y_next;
    logic signed [bfki_pkg::ANGLE_W-1:0] z_reg, z_next;
    logic                                flip_reg, flip_next;
    logic [bfki_pkg::ITER_W-1:0]         cnt_reg, cnt_next;
    logic                                running_reg, running_next;
    logic                                done_reg, done_next;

    logic signed [bfki_pkg::ANGLE_W-1:0] a_ext;
    logic signed [bfki_pkg::ANGLE_W-1:0] a_fold;
    logic                                a_flip;
    logic signed [bfki_pkg::CORD_W-1:0]  dx, dy;
    logic signed [bfki_pkg::ANGLE_W-1:0] at;
    logic                                last;

    // Fold the angle into the right half plane; the far half is a negation.
    always_comb
    begin
        a_ext  = signed'({{(bfki_pkg::ANGLE_W - bfki_pkg::PHASE_W){phase[bfki_pkg::PHASE_W-1]}},
                          phase});
        a_fold = a_ext;
        a_flip = 1'b0;
        if (a_ext > QUARTER_TURN)
        begin
            a_fold = a_ext - HALF_TURN;
            a_flip = 1'b1;
        end
        else if (a_ext < -QUARTER_TURN)
        begin
            a_fold = a_ext + HALF_TURN;
            a_flip = 1'b1;
        end
    end

    always_comb
    begin
        dx   = x_reg >>> cnt_reg;
        dy   = y_reg >>> cnt_reg;
        at   = signed'(bfki_pkg::ANGLE_W'(bfki_pkg::atan_turns(bfki_pkg::ATAN_IDX_W'(cnt_reg))));
        last = (cnt_reg == bfki_pkg::ITER_W'(bfki_pkg::CORDIC_ITERATIONS - 1));

        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        flip_next    = flip_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;

        if (start)
        begin
            x_next       = signed'(bfki_pkg::CORDIC_GAIN);
            y_next       = '0;
            z_next       = a_fold;
            flip_next    = a_flip;
            cnt_next     = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            if (!z_reg[bfki_pkg::ANGLE_W-1])
            begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign cos_value   = flip_reg ? -x_reg : x_reg;
    assign sin_value   = flip_reg ? -y_reg : y_reg;
    assign status.busy = running_reg;
    assign status.done = done_reg;

endmodule

// File: src/bessel_first_kind_integral_unit.sv
// ============================================================================
// bessel_first_kind_integral_unit
// J_m(x) by the trapezoid rule over 0..pi, on one shared CORDIC and multiplier.
// ============================================================================
// Usage. An input beat (x_value in unsigned Q5.16, order m in 0..15) is taken
// at a rising edge where start is high and busy is low. busy rises on the
// next cycle and stays high until the item is finished; no new beat is taken
// meanwhile. The result beat, bessel_value in signed Q1.16 saturated to plus
// or minus one, is shown for exactly one cycle with done high. The receiver
// cannot stall the block, so it must take the beat in that cycle.
// The panel count 2^steps_log2 comes from the one register, written with
// cfg_write and cfg_data while idle, a rule for the user that the block does
// not enforce. Clamped to 4..14, it is sampled when an item is accepted.
// Sequence. Every sample point runs the CORDIC twice (sin of theta, then cos of
// the integrand phase) with two passes through the shared multiplier between
// them. An item with N panels visits N + 1 points, and the CORDIC
// micro-rotation loop takes most of the time of each point.
// Reset. rst_n is asynchronous and active low; it returns the block to idle
// and sets steps_log2 to 10.
// ============================================================================
module bessel_first_kind_integral_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [bfki_pkg::X_W-1:0]             x_value,
    input  logic [bfki_pkg::ORDER_W-1:0]         order,
    input  logic                                 cfg_write,
    input  logic [bfki_pkg::STEPS_W-1:0]         cfg_data,
    output logic                                 done,
    output logic signed [bfki_pkg::OUT_W-1:0]    bessel_value
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_THETA  = 3'd1;  // launch CORDIC on theta_k
    localparam logic [2:0] ST_ROT1   = 3'd2;  // wait for sin(theta_k)
    localparam logic [2:0] ST_MUL1   = 3'd3;  // x * sin(theta_k)
    localparam logic [2:0] ST_MUL2   = 3'd4;  // radians to turns
    localparam logic [2:0] ST_PHASE  = 3'd5;  // launch CORDIC on m*theta - x*sin
    localparam logic [2:0] ST_ROT2   = 3'd6;  // wait for the cosine sample
    localparam logic [2:0] ST_ACC    = 3'd7;  // weight and accumulate

    logic [2:0]                          state_reg, state_next;
    logic                                final_reg, final_next;
    logic [bfki_pkg::STEPS_W-1:0]        steps_reg, steps_next;
    logic [bfki_pkg::K_W-1:0]            k_reg, k_next;
    logic signed [bfki_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic                                done_reg, done_next;

    logic [bfki_pkg::X_W-1:0]            x_reg;
    logic [bfki_pkg::ORDER_W-1:0]        order_reg;
    logic [bfki_pkg::S_W-1:0]            s_reg;
    logic signed [bfki_pkg::PROD_W-1:0]  prod_reg;
    logic [bfki_pkg::PHASE_W-1:0]        ordtheta_reg;
    logic signed [bfki_pkg::OUT_W-1:0]   result_reg, result_next;

    logic [bfki_pkg::S_W-1:0]            s_clamped;
    logic [bfki_pkg::K_W-1:0]            n_value;
    logic [bfki_pkg::PSH_W-1:0]          theta_shift;
    logic [bfki_pkg::PHASE_W-1:0]        theta;
    logic [bfki_pkg::ORDER_W+bfki_pkg::K_W-1:0] ordk;
    logic [bfki_pkg::PHASE_W-1:0]        ordtheta;
    logic [bfki_pkg::PHASE_W-1:0]        turns;

    logic signed [bfki_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [bfki_pkg::PROD_W-1:0]  prod_full;

    logic                                cordic_start;
    logic [bfki_pkg::PHASE_W-1:0]        cordic_phase;
    bfki_pkg::cordic_status_t            cordic_status;
    logic signed [bfki_pkg::CORD_W-1:0]  cos_value, sin_value;

    logic signed [bfki_pkg::CORD_W-1:0]  cos_rounded;
    logic signed [bfki_pkg::CF_W-1:0]    cf;
    logic signed [bfki_pkg::SUM_W-1:0]   cf_ext;
    logic signed [bfki_pkg::SUM_W-1:0]   sum_rounded;
    logic signed [bfki_pkg::SUM_W-1:0]   sum_scaled;
    logic                                endpoint;

    localparam logic signed [bfki_pkg::SUM_W-1:0] ONE_Q =
        bfki_pkg::SUM_W'(64'sd1 <<< bfki_pkg::FRAC_BITS);
    localparam logic signed [bfki_pkg::CORD_W-1:0] CF_ROUND =
        bfki_pkg::CORD_W'(64'sd1 <<< (bfki_pkg::CF_SHIFT - 1));

    bfki_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cordic_start),
        .phase     (cordic_phase),
        .status    (cordic_status),
        .cos_value (cos_value),
        .sin_value (sin_value)
    );

    // Clamp the register to the supported panel range.
    always_comb
    begin
        if (steps_reg < bfki_pkg::STEPS_W'(bfki_pkg::MIN_STEPS_LOG2))
            s_clamped = bfki_pkg::S_W'(bfki_pkg::MIN_STEPS_LOG2);
        else if (steps_reg > bfki_pkg::STEPS_W'(bfki_pkg::MAX_STEPS_LOG2))
            s_clamped = bfki_pkg::S_W'(bfki_pkg::MAX_STEPS_LOG2);
        else
            s_clamped = bfki_pkg::S_W'(steps_reg);
    end

    // Sample angle theta_k = k*pi/N is k shifted up into a half turn.
    always_comb
    begin
        n_value     = bfki_pkg::K_W'(1) << s_reg;
        theta_shift = bfki_pkg::PSH_W'(bfki_pkg::PHASE_W - 1) - bfki_pkg::PSH_W'(s_reg);
        theta       = bfki_pkg::PHASE_W'(k_reg) << theta_shift;
        ordk        = (bfki_pkg::ORDER_W + bfki_pkg::K_W)'(order_reg)
                    * (bfki_pkg::ORDER_W + bfki_pkg::K_W)'(k_reg);
        ordtheta    = bfki_pkg::PHASE_W'(ordk) << theta_shift;
        turns       = prod_reg[bfki_pkg::RAD_FRAC + bfki_pkg::PHASE_W - 1 : bfki_pkg::RAD_FRAC];
    end

    // Shared multiplier: x*sin(theta) first, then radians times 1/(2*pi).
    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul_a = prod_reg[bfki_pkg::RAD_SHIFT + bfki_pkg::MUL_W - 1 : bfki_pkg::RAD_SHIFT];
            mul_b = signed'(bfki_pkg::INV_TWO_PI);
        end
        else
        begin
            mul_a = signed'(bfki_pkg::MUL_W'(x_reg));
            mul_b = sin_value[bfki_pkg::MUL_W-1:0];
        end
    end

    assign prod_full = mul_a * mul_b;

    assign cordic_start = (state_reg == ST_THETA) || (state_reg == ST_PHASE);
    assign cordic_phase = (state_reg == ST_PHASE) ? (ordtheta_reg - turns) : theta;

    // Cosine sample rounded half up to FRAC_BITS, then the final scaling.
    always_comb
    begin
        cos_rounded = cos_value + CF_ROUND;
        cf          = cos_rounded[bfki_pkg::CORD_W-1:bfki_pkg::CF_SHIFT];
        cf_ext      = bfki_pkg::SUM_W'(cf);
        endpoint    = (k_reg == '0) || (k_reg == n_value);
        sum_rounded = sum_reg + (bfki_pkg::SUM_W'(1) << s_reg);
        sum_scaled  = sum_rounded >>> (s_reg + 1'b1);
        if (sum_scaled > ONE_Q)
            result_next = bfki_pkg::OUT_W'(ONE_Q);
        else if (sum_scaled < -ONE_Q)
            result_next = bfki_pkg::OUT_W'(-ONE_Q);
        else
            result_next = bfki_pkg::OUT_W'(sum_scaled);
    end

    always_comb
    begin
        state_next = state_reg;
        final_next = 1'b0;
        steps_next = steps_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        done_next  = final_reg;

        if (cfg_write)
            steps_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !final_reg)
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = ST_THETA;
                end
            end
            ST_THETA:
                state_next = ST_ROT1;
            ST_ROT1:
            begin
                if (cordic_status.done)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
                state_next = ST_MUL2;
            ST_MUL2:
                state_next = ST_PHASE;
            ST_PHASE:
                state_next = ST_ROT2;
            ST_ROT2:
            begin
                if (cordic_status.done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next = endpoint ? (sum_reg + cf_ext) : (sum_reg + (cf_ext <<< 1));
                if (k_reg == n_value)
                begin
                    final_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_THETA;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            steps_reg <= bfki_pkg::STEPS_W'(bfki_pkg::STEPS_RESET);
            k_reg     <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            steps_reg <= steps_next;
            k_reg     <= k_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    // Item operands, multiplier output and the result word carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && !final_reg)
        begin
            x_reg     <= x_value;
            order_reg <= order;
            s_reg     <= s_clamped;
        end
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2)
            prod_reg <= prod_full;
        if (state_reg == ST_MUL1)
            ordtheta_reg <= ordtheta;
        if (final_reg)
            result_reg <= result_next;
    end

    // The last cycle of summing and the scaling cycle count as busy, so no
    // beat is taken before the result word is formed. A new beat can be
    // taken in the cycle that shows the result.
    assign busy         = (state_reg != ST_IDLE) || final_reg;
    assign done         = done_reg;
    assign bessel_value = result_reg;

    // An accepted beat keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");

    // A result only follows the scaling cycle of an item.
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(final_reg))
        else $error("result strobe without a finished sum");

    // The sample index never passes the last panel edge while working.
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg <= n_value))
        else $error("sample index beyond the panel count");

    // The result is always within plus or minus one.
    a_result_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((bessel_value <= bfki_pkg::OUT_W'(ONE_Q))
              && (bessel_value >= bfki_pkg::OUT_W'(-ONE_Q))))
        else $error("result outside the saturation range");

endmodule
